FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked and disabled during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: sv/ffra_pkg.sv
// ----------------------------------------------------------------------------
// ffra_pkg
// shared sizes, codes and controller/datapath interface types
// ----------------------------------------------------------------------------
package ffra_pkg;

    localparam int FREE_SLOTS  = 16;
    localparam int GRANT_SLOTS = 16;
    localparam int PAGE_BITS   = 12;

    localparam int FI_W = $clog2(FREE_SLOTS);
    localparam int FC_W = $clog2(FREE_SLOTS + 1);
    localparam int GI_W = (GRANT_SLOTS > 1) ? $clog2(GRANT_SLOTS) : 1;
    localparam int GC_W = $clog2(GRANT_SLOTS + 1);

    localparam int ADDR_W     = 48;
    localparam int SIZE_W     = 32;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 48;

    localparam logic [CFG_IDX_W-1:0] REG_POOL_BASE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_POOL_SIZE = 1'b1;

    typedef enum logic [1:0] {
        CMD_INIT  = 2'd0,
        CMD_ALLOC = 2'd1,
        CMD_FREE  = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_NO_FIT      = 2'd1,
        ST_NOT_GRANTED = 2'd2,
        ST_FULL        = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_INIT,
        DP_FSTEP,
        DP_GINC,
        DP_TAKE,
        DP_JOIN,
        DP_RELEASE,
        DP_WR_BOTH,
        DP_WR_PREV,
        DP_WR_NEXT,
        DP_INS,
        DP_DROP
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic              f_end;
        logic              fit;
        logic              exact;
        logic              above;
        logic              f_full;
        logic              g_end;
        logic              g_hit;
        logic              g_full;
        logic              jp;
        logic              jn;
        logic              drop_last;
        logic              ins_last;
        logic [ADDR_W-1:0] out_addr;
    } t_dp_stat;

endpackage

FILE: sv/ffra_dp.sv
// ----------------------------------------------------------------------------
// ffra_dp
// region tables, scan indexes and arithmetic of the allocator
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ffra_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [ffra_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ffra_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic [ffra_pkg::ADDR_W-1:0]     i_req_address,
    input  logic [ffra_pkg::SIZE_W-1:0]     i_req_size,
    input  ffra_pkg::t_dp_cmd               i_cmd,
    output ffra_pkg::t_dp_stat              o_stat
);
    import ffra_pkg::*;

    localparam logic [SIZE_W:0] PAGE_M1 = (SIZE_W+1)'((64'd1 << PAGE_BITS) - 64'd1);

    function automatic logic [SIZE_W-1:0] sat32(input logic [SIZE_W+2:0] v);
        return (|v[SIZE_W+2:SIZE_W]) ? '1 : v[SIZE_W-1:0];
    endfunction

    logic [ADDR_W-1:0] r_pool_base;
    logic [SIZE_W-1:0] r_pool_size;

    logic [ADDR_W-1:0] r_fs [FREE_SLOTS];
    logic [SIZE_W-1:0] r_fl [FREE_SLOTS];
    logic [ADDR_W-1:0] r_gs [GRANT_SLOTS];
    logic [SIZE_W-1:0] r_gl [GRANT_SLOTS];
    logic [GRANT_SLOTS-1:0] r_gv;

    logic [FC_W-1:0]   r_count;
    logic [FC_W-1:0]   r_fidx;
    logic [GC_W-1:0]   r_gidx;
    logic [ADDR_W-1:0] r_addr;
    logic [SIZE_W-1:0] r_size;
    logic [SIZE_W:0]   r_len;
    logic [ADDR_W:0]   r_prev_end;
    logic [SIZE_W-1:0] r_prev_len;
    logic [SIZE_W-1:0] r_next_len;
    logic [FC_W-1:0]   r_ins;
    logic [SIZE_W+1:0] r_acc;
    logic              r_jp;
    logic              r_jn;
    logic [ADDR_W-1:0] r_out;

    logic [SIZE_W:0]   len_sum;
    logic [SIZE_W:0]   len_next;
    logic [FC_W-1:0]   rd_cnt;
    logic [FI_W-1:0]   rd_idx;
    logic [ADDR_W-1:0] fs_rd;
    logic [SIZE_W-1:0] fl_rd;
    logic [GI_W-1:0]   gi;
    logic [ADDR_W-1:0] gs_rd;
    logic [SIZE_W-1:0] gl_rd;
    logic [GI_W-1:0]   g_free;
    logic              f_end;
    logic              drop_last;
    logic              ins_last;
    logic              exact;
    logic              f_we_s;
    logic              f_we_l;
    logic [FC_W-1:0]   wr_cnt;
    logic [ADDR_W-1:0] wr_s;
    logic [SIZE_W-1:0] wr_l;

    assign len_sum  = {1'b0, i_req_size} + PAGE_M1;
    assign len_next = len_sum & ~PAGE_M1;

    always_comb begin
        case (i_cmd.op)
            DP_DROP: rd_cnt = r_fidx + FC_W'(1);
            DP_INS:  rd_cnt = r_fidx - FC_W'(1);
            default: rd_cnt = r_fidx;
        endcase
    end

    assign rd_idx = rd_cnt[FI_W-1:0];
    assign fs_rd  = r_fs[rd_idx];
    assign fl_rd  = r_fl[rd_idx];
    assign gi     = r_gidx[GI_W-1:0];
    assign gs_rd  = r_gs[gi];
    assign gl_rd  = r_gl[gi];

    // lowest unused grant slot
    always_comb begin
        g_free = '0;
        for (int k = GRANT_SLOTS - 1; k >= 0; k--) begin
            if (!r_gv[k]) begin
                g_free = GI_W'(k);
            end
        end
    end

    assign f_end     = (r_fidx == r_count);
    assign drop_last = (({1'b0, r_fidx} + (FC_W+1)'(1)) >= {1'b0, r_count});
    assign ins_last  = (r_fidx == r_ins);
    assign exact     = ({1'b0, fl_rd} == r_len);

    always_comb begin
        o_stat           = '0;
        o_stat.f_end     = f_end;
        o_stat.fit       = ({1'b0, fl_rd} >= r_len);
        o_stat.exact     = exact;
        o_stat.above     = (fs_rd > r_addr);
        o_stat.f_full    = (r_count >= FC_W'(FREE_SLOTS));
        o_stat.g_end     = (r_gidx == GC_W'(GRANT_SLOTS));
        o_stat.g_hit     = r_gv[gi] && (r_addr >= gs_rd) &&
                           (({1'b0, r_addr} + (ADDR_W+1)'(r_size)) <=
                            ({1'b0, gs_rd} + (ADDR_W+1)'(gl_rd)));
        o_stat.g_full    = &r_gv;
        o_stat.jp        = r_jp;
        o_stat.jn        = r_jn;
        o_stat.drop_last = drop_last;
        o_stat.ins_last  = ins_last;
        o_stat.out_addr  = r_out;
    end

    // free table write port
    always_comb begin
        f_we_s = 1'b0;
        f_we_l = 1'b0;
        wr_cnt = r_fidx;
        wr_s   = fs_rd;
        wr_l   = fl_rd;
        case (i_cmd.op)
            DP_INIT: begin
                f_we_s = 1'b1;
                f_we_l = 1'b1;
                wr_cnt = '0;
                wr_s   = r_pool_base;
                wr_l   = r_pool_size;
            end
            DP_TAKE: begin
                f_we_s = !exact;
                f_we_l = !exact;
                wr_s   = fs_rd + ADDR_W'(r_len);
                wr_l   = fl_rd - r_len[SIZE_W-1:0];
            end
            DP_WR_BOTH: begin
                f_we_l = 1'b1;
                wr_cnt = r_ins - FC_W'(1);
                wr_l   = sat32((SIZE_W+3)'(r_acc) + (SIZE_W+3)'(r_next_len));
            end
            DP_WR_PREV: begin
                f_we_l = 1'b1;
                wr_cnt = r_ins - FC_W'(1);
                wr_l   = sat32((SIZE_W+3)'(r_acc));
            end
            DP_WR_NEXT: begin
                f_we_s = 1'b1;
                f_we_l = 1'b1;
                wr_cnt = r_ins;
                wr_s   = r_addr;
                wr_l   = sat32((SIZE_W+3)'(r_acc));
            end
            DP_INS: begin
                f_we_s = 1'b1;
                f_we_l = 1'b1;
                if (ins_last) begin
                    wr_s = r_addr;
                    wr_l = sat32((SIZE_W+3)'(r_len));
                end
            end
            DP_DROP: begin
                f_we_s = !drop_last;
                f_we_l = !drop_last;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (f_we_s) begin
            r_fs[wr_cnt[FI_W-1:0]] <= wr_s;
        end
        if (f_we_l) begin
            r_fl[wr_cnt[FI_W-1:0]] <= wr_l;
        end
        if (i_cmd.op == DP_TAKE) begin
            r_gs[g_free] <= fs_rd;
            r_gl[g_free] <= r_size;
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            DP_LOAD: begin
                r_addr     <= i_req_address;
                r_size     <= i_req_size;
                r_len      <= len_next;
                r_prev_end <= '0;
                r_prev_len <= '0;
                r_out      <= '0;
            end
            DP_FSTEP: begin
                r_prev_end <= {1'b0, fs_rd} + (ADDR_W+1)'(fl_rd);
                r_prev_len <= fl_rd;
            end
            DP_TAKE: begin
                r_out <= fs_rd;
            end
            DP_JOIN: begin
                r_next_len <= fl_rd;
            end
            DP_RELEASE: begin
                r_acc <= (SIZE_W+2)'(r_len) +
                         (r_jp ? (SIZE_W+2)'(r_prev_len) :
                          r_jn ? (SIZE_W+2)'(r_next_len) : '0);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_base <= '0;
            r_pool_size <= '0;
            r_gv        <= '0;
            r_count     <= '0;
            r_fidx      <= '0;
            r_gidx      <= '0;
            r_ins       <= '0;
            r_jp        <= 1'b0;
            r_jn        <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_POOL_BASE: r_pool_base <= i_cfg_data[ADDR_W-1:0];
                    REG_POOL_SIZE: r_pool_size <= i_cfg_data[SIZE_W-1:0];
                    default: begin
                    end
                endcase
            end
            case (i_cmd.op)
                DP_LOAD: begin
                    r_fidx <= '0;
                    r_gidx <= '0;
                end
                DP_INIT: begin
                    r_gv    <= '0;
                    r_count <= (r_pool_size != '0) ? FC_W'(1) : '0;
                end
                DP_FSTEP: r_fidx <= r_fidx + FC_W'(1);
                DP_GINC:  r_gidx <= r_gidx + GC_W'(1);
                DP_TAKE:  r_gv[g_free] <= 1'b1;
                DP_JOIN: begin
                    r_jp  <= (r_fidx != '0) && (r_prev_end == {1'b0, r_addr});
                    r_jn  <= !f_end &&
                             ({1'b0, fs_rd} == ({1'b0, r_addr} + (ADDR_W+1)'(r_len)));
                    r_ins <= r_fidx;
                end
                DP_RELEASE: begin
                    r_gv[gi] <= 1'b0;
                    r_fidx   <= r_count;
                end
                DP_WR_BOTH: r_fidx <= r_ins;
                DP_INS: begin
                    if (ins_last) begin
                        r_count <= r_count + FC_W'(1);
                    end else begin
                        r_fidx <= r_fidx - FC_W'(1);
                    end
                end
                DP_DROP: begin
                    if (drop_last) begin
                        r_count <= r_count - FC_W'(1);
                    end else begin
                        r_fidx <= r_fidx + FC_W'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    `ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= FC_W'(FREE_SLOTS))
    `ASSERT_NEXT(a_ins_grows, i_clk, i_rst_n, (i_cmd.op == DP_INS) && ins_last, r_count == $past(r_count) + FC_W'(1))
    `ASSERT_NEXT(a_take_marks, i_clk, i_rst_n, i_cmd.op == DP_TAKE, $countones(r_gv) == $countones($past(r_gv)) + 1)

endmodule

FILE: sv/ffra_ctrl.sv
// ----------------------------------------------------------------------------
// ffra_ctrl
// request sequencer and result register of the allocator
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ffra_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [1:0]                  i_command,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [1:0]                  o_status,
    output logic [ffra_pkg::ADDR_W-1:0] o_out_address,
    output ffra_pkg::t_dp_cmd           o_cmd,
    input  ffra_pkg::t_dp_stat          i_stat
);
    import ffra_pkg::*;

    typedef enum logic [11:0] {
        S_IDLE   = 12'b000000000001,
        S_INIT   = 12'b000000000010,
        S_ASCAN  = 12'b000000000100,
        S_GSCAN  = 12'b000000001000,
        S_FSCAN  = 12'b000000010000,
        S_DECIDE = 12'b000000100000,
        S_BOTH   = 12'b000001000000,
        S_PREV   = 12'b000010000000,
        S_NEXT   = 12'b000100000000,
        S_INS    = 12'b001000000000,
        S_DROP   = 12'b010000000000,
        S_DONE   = 12'b100000000000
    } t_state;

    t_state            r_state, n_state;
    t_status           r_res, n_res;
    logic              r_out_valid;
    logic [1:0]        r_status;
    logic [ADDR_W-1:0] r_out_address;
    logic              accept;
    logic              deliver;

    assign o_in_ready    = (r_state == S_IDLE);
    assign accept        = i_in_valid && o_in_ready;
    assign deliver       = (r_state == S_DONE) && (!r_out_valid || i_out_ready);
    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_out_address = r_out_address;

    always_comb begin
        n_state  = r_state;
        n_res    = r_res;
        o_cmd.op = DP_NOP;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.op = DP_LOAD;
                    n_res    = ST_OK;
                    case (t_cmd'(i_command))
                        CMD_INIT:  n_state = S_INIT;
                        CMD_ALLOC: n_state = S_ASCAN;
                        CMD_FREE:  n_state = S_GSCAN;
                        default:   n_state = S_DONE;
                    endcase
                end
            end
            S_INIT: begin
                o_cmd.op = DP_INIT;
                n_state  = S_DONE;
            end
            S_ASCAN: begin
                if (i_stat.f_end) begin
                    n_res   = ST_NO_FIT;
                    n_state = S_DONE;
                end else if (i_stat.fit) begin
                    if (i_stat.g_full) begin
                        n_res   = ST_FULL;
                        n_state = S_DONE;
                    end else begin
                        o_cmd.op = DP_TAKE;
                        n_state  = i_stat.exact ? S_DROP : S_DONE;
                    end
                end else begin
                    o_cmd.op = DP_FSTEP;
                end
            end
            S_GSCAN: begin
                if (i_stat.g_end) begin
                    n_res   = ST_NOT_GRANTED;
                    n_state = S_DONE;
                end else if (i_stat.g_hit) begin
                    n_state = S_FSCAN;
                end else begin
                    o_cmd.op = DP_GINC;
                end
            end
            S_FSCAN: begin
                if (i_stat.f_end || i_stat.above) begin
                    o_cmd.op = DP_JOIN;
                    n_state  = S_DECIDE;
                end else begin
                    o_cmd.op = DP_FSTEP;
                end
            end
            S_DECIDE: begin
                if (!i_stat.jp && !i_stat.jn && i_stat.f_full) begin
                    n_res   = ST_FULL;
                    n_state = S_DONE;
                end else begin
                    o_cmd.op = DP_RELEASE;
                    if (i_stat.jp && i_stat.jn) begin
                        n_state = S_BOTH;
                    end else if (i_stat.jp) begin
                        n_state = S_PREV;
                    end else if (i_stat.jn) begin
                        n_state = S_NEXT;
                    end else begin
                        n_state = S_INS;
                    end
                end
            end
            S_BOTH: begin
                o_cmd.op = DP_WR_BOTH;
                n_state  = S_DROP;
            end
            S_PREV: begin
                o_cmd.op = DP_WR_PREV;
                n_state  = S_DONE;
            end
            S_NEXT: begin
                o_cmd.op = DP_WR_NEXT;
                n_state  = S_DONE;
            end
            S_INS: begin
                o_cmd.op = DP_INS;
                if (i_stat.ins_last) begin
                    n_state = S_DONE;
                end
            end
            S_DROP: begin
                o_cmd.op = DP_DROP;
                if (i_stat.drop_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (deliver) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_res       <= ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_res   <= n_res;
            if (deliver) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (deliver) begin
            r_status      <= r_res;
            r_out_address <= i_stat.out_addr;
        end
    end

    `ASSERT_NEXT(a_accept_leaves_idle, i_clk, i_rst_n, accept, r_state != S_IDLE)
    `ASSERT_NEXT(a_done_waits, i_clk, i_rst_n, (r_state == S_DONE) && r_out_valid && !i_out_ready, r_state == S_DONE)
    `ASSERT_ALWAYS(a_addr_only_ok, i_clk, i_rst_n, !r_out_valid || r_status == ST_OK || r_out_address == '0)

endmodule

FILE: sv/first_fit_region_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_region_allocator
// first-fit allocator with coalescing free table for a device address pool
// ----------------------------------------------------------------------------
// One request at a time: a request is taken only while the block is idle, and
// its result sits in an output register so the next request can be taken
// while that result waits. The time a request takes is set by the sequential
// walks over the tables through one read port of each: init loads the pool,
// if its size is nonzero, as a single region; allocate scans the regions and,
// when a region is used up, shifts the regions after it down; free scans the
// grant slots, then the regions, and may then shift regions up or down. Sizes
// are rounded up to a multiple of 2^PAGE_BITS bytes; pool_base and pool_size
// may be written only while no request is in flight, and take effect at the
// next init request.
// ----------------------------------------------------------------------------
module first_fit_region_allocator (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration writes
    input  logic                            i_cfg_we,
    input  logic [ffra_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ffra_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // request channel
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [1:0]                      i_command,
    input  logic [ffra_pkg::ADDR_W-1:0]     i_req_address,
    input  logic [ffra_pkg::SIZE_W-1:0]     i_req_size,
    // result channel
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [1:0]                      o_status,
    output logic [ffra_pkg::ADDR_W-1:0]     o_out_address
);
    import ffra_pkg::*;

    // micro-op from the sequencer, flags back from the tables
    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    ffra_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_command     (i_command),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_status      (o_status),
        .o_out_address (o_out_address),
        .o_cmd         (dp_cmd),
        .i_stat        (dp_stat)
    );

    // datapath captures the request payload when the sequencer issues a load
    ffra_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_req_address (i_req_address),
        .i_req_size    (i_req_size),
        .i_cmd         (dp_cmd),
        .o_stat        (dp_stat)
    );

endmodule
